/* design/bfq_pkg.sv */
// ----------------------------------------------------------------------------
// bfq_pkg
// Shared types and constants of the battery fault qualifier: opcodes, bank
// codes, register indexes, category bits and the structs between modules.
// ----------------------------------------------------------------------------
package bfq_pkg;

  localparam int OP_W    = 2;
  localparam int CAT_W   = 3;
  localparam int CH_W    = 5;
  localparam int CNT_W   = 8;
  localparam int CODE_W  = 5;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 3;

  localparam int CH_SPAN   = 1 << CH_W;
  localparam int NUM_BANKS = 1 << CAT_W;

  localparam int DEF_CELLS               = 32;
  localparam int DEF_CHIPS               = 4;
  localparam int DEF_TEMP_SENSORS        = 32;
  localparam int DEF_CV_GROUPS_PER_CHIP  = 4;
  localparam int DEF_AUX_GROUPS_PER_CHIP = 2;

  localparam logic [CNT_W-1:0] LIMIT_RESET      = 8'd30;
  localparam logic [CNT_W-1:0] TEMP_LIMIT_RESET = 8'd10;
  localparam logic [CNT_W-1:0] CNT_MAX          = '1;

  localparam logic [CODE_W-1:0] BIT_TEMPERATURE = 5'(1 << 0);
  localparam logic [CODE_W-1:0] BIT_VOLTAGE     = 5'(1 << 1);
  localparam logic [CODE_W-1:0] BIT_SELF_TEST   = 5'(1 << 2);
  localparam logic [CODE_W-1:0] BIT_SENSE_LINE  = 5'(1 << 4);

  typedef enum logic [OP_W-1:0] {
    OP_INC    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_REINIT = 2'd3
  } opcode_t;

  typedef enum logic [CAT_W-1:0] {
    CAT_VRANGE   = 3'd0,
    CAT_VMISSING = 3'd1,
    CAT_SENSE    = 3'd2,
    CAT_TRANGE   = 3'd3,
    CAT_TMISSING = 3'd4,
    CAT_CVTEST   = 3'd5,
    CAT_AUXTEST  = 3'd6,
    CAT_MUXTEST  = 3'd7
  } cat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLTAGE_RANGE   = 3'd0,
    CFG_MISSING_VOLTAGE = 3'd1,
    CFG_SENSE_LINE      = 3'd2,
    CFG_TEMP_RANGE      = 3'd3,
    CFG_MISSING_TEMP    = 3'd4,
    CFG_SELF_TEST       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0] voltage_range;
    logic [CNT_W-1:0] missing_voltage;
    logic [CNT_W-1:0] sense_line;
    logic [CNT_W-1:0] temp_range;
    logic [CNT_W-1:0] missing_temp;
    logic [CNT_W-1:0] self_test;
  } limits_t;

  typedef struct packed {
    logic            fire;
    opcode_t         op;
    cat_t            cat;
    logic [CH_W-1:0] ch;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [CODE_W-1:0] fault_code;
    logic              relay_closed;
    logic              index_error;
  } rsp_t;

endpackage

/* design/bfq_req_if.sv */
// ----------------------------------------------------------------------------
// bfq_req_if
// Request channel: one operation on one fault counter.
// ----------------------------------------------------------------------------
interface bfq_req_if;
  logic                        valid;
  logic                        ready;
  logic [bfq_pkg::OP_W-1:0]    opcode;
  logic [bfq_pkg::CAT_W-1:0]   category;
  logic [bfq_pkg::CH_W-1:0]    channel;

  modport source (output valid, opcode, category, channel, input ready);
  modport sink   (input valid, opcode, category, channel, output ready);
endinterface

/* design/bfq_rsp_if.sv */
// ----------------------------------------------------------------------------
// bfq_rsp_if
// Result channel: counter value, fault code, relay and index status.
// ----------------------------------------------------------------------------
interface bfq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bfq_pkg::CNT_W-1:0]   count;
  logic [bfq_pkg::CODE_W-1:0]  fault_code;
  logic                        relay_closed;
  logic                        index_error;

  modport source (output valid, count, fault_code, relay_closed, index_error,
                  input ready);
  modport sink   (input valid, count, fault_code, relay_closed, index_error,
                  output ready);
endinterface

/* design/battery_fault_qualifier_top.sv */
// ----------------------------------------------------------------------------
// battery_fault_qualifier_top
// Battery-monitor fault qualifier: per-channel fault counters with limits,
// sticky fault code and shutdown relay latch.
// ----------------------------------------------------------------------------
// Usage:
//   req  : valid/ready channel carrying opcode, category and channel.
//   rsp  : valid/ready channel with count, fault_code, relay_closed and
//          index_error; exactly one result per request, in order.
//   cfg_*: plain write port for the six trip limits (index 0..5); writes
//          to other indexes are dropped. Write only while the block is idle.
// Timing:
//   A transfer on req lands in an input register; once it advances, the
//   counter bank reads, updates and writes back the addressed counter and
//   the result is captured in the output register, which drives rsp.valid;
//   one request per cycle is taken sustained while rsp.ready stays high,
//   set by the single read-modify-write of the counter banks.
// Reset (rst, synchronous): counters and fault code clear, relay closed,
//   limits return to their defaults, both channels empty.
// Stall: while rsp.ready is low the result holds; the input register still
//   takes one more request, then req.ready drops until the result leaves.
// ----------------------------------------------------------------------------
module battery_fault_qualifier_top #(
  parameter int CELLS               = bfq_pkg::DEF_CELLS,
  parameter int CHIPS               = bfq_pkg::DEF_CHIPS,
  parameter int TEMP_SENSORS        = bfq_pkg::DEF_TEMP_SENSORS,
  parameter int CV_GROUPS_PER_CHIP  = bfq_pkg::DEF_CV_GROUPS_PER_CHIP,
  parameter int AUX_GROUPS_PER_CHIP = bfq_pkg::DEF_AUX_GROUPS_PER_CHIP
) (
  input  logic                          clk,
  input  logic                          rst,
  bfq_req_if.sink                       req,
  bfq_rsp_if.source                     rsp,
  input  logic                          cfg_we,
  input  logic [bfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfq_pkg::CFG_W-1:0]     cfg_data
);

  logic                      s1_valid;
  logic                      s1_valid_next;
  bfq_pkg::opcode_t          s1_op;
  bfq_pkg::cat_t             s1_cat;
  logic [bfq_pkg::CH_W-1:0]  s1_ch;
  logic                      out_valid;
  logic                      out_valid_next;
  logic                      advance;
  logic                      take;

  bfq_pkg::limits_t          limits;
  bfq_pkg::req_t             bank_req;
  bfq_pkg::rsp_t             bank_rsp;
  bfq_pkg::rsp_t             out_data;

  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign take      = req.valid && req.ready;

  always_comb begin
    s1_valid_next = s1_valid;
    if (take) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end
    out_valid_next = out_valid;
    if (advance) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // hold the request until it moves to the result register
  always_ff @(posedge clk) begin
    if (take) begin
      s1_op  <= bfq_pkg::opcode_t'(req.opcode);
      s1_cat <= bfq_pkg::cat_t'(req.category);
      s1_ch  <= req.channel;
    end
    if (advance) begin
      out_data <= bank_rsp;
    end
  end

  assign bank_req.fire = advance;
  assign bank_req.op   = s1_op;
  assign bank_req.cat  = s1_cat;
  assign bank_req.ch   = s1_ch;

  bfq_limit_regs u_limits (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  bfq_counter_banks #(
    .CELLS               (CELLS),
    .CHIPS               (CHIPS),
    .TEMP_SENSORS        (TEMP_SENSORS),
    .CV_GROUPS_PER_CHIP  (CV_GROUPS_PER_CHIP),
    .AUX_GROUPS_PER_CHIP (AUX_GROUPS_PER_CHIP)
  ) u_banks (
    .clk    (clk),
    .rst    (rst),
    .req    (bank_req),
    .limits (limits),
    .rsp    (bank_rsp)
  );

  assign rsp.valid        = out_valid;
  assign rsp.count        = out_data.count;
  assign rsp.fault_code   = out_data.fault_code;
  assign rsp.relay_closed = out_data.relay_closed;
  assign rsp.index_error  = out_data.index_error;

endmodule

/* design/bfq_limit_regs.sv */
// ----------------------------------------------------------------------------
// bfq_limit_regs
// Trip limit registers, written through the plain configuration port.
// ----------------------------------------------------------------------------
module bfq_limit_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bfq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfq_pkg::CFG_W-1:0]        cfg_data,
  output bfq_pkg::limits_t                 limits
);

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.voltage_range   <= bfq_pkg::LIMIT_RESET;
      limits.missing_voltage <= bfq_pkg::LIMIT_RESET;
      limits.sense_line      <= bfq_pkg::LIMIT_RESET;
      limits.temp_range      <= bfq_pkg::TEMP_LIMIT_RESET;
      limits.missing_temp    <= bfq_pkg::LIMIT_RESET;
      limits.self_test       <= bfq_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfq_pkg::CFG_VOLTAGE_RANGE:   limits.voltage_range   <= cfg_data;
        bfq_pkg::CFG_MISSING_VOLTAGE: limits.missing_voltage <= cfg_data;
        bfq_pkg::CFG_SENSE_LINE:      limits.sense_line      <= cfg_data;
        bfq_pkg::CFG_TEMP_RANGE:      limits.temp_range      <= cfg_data;
        bfq_pkg::CFG_MISSING_TEMP:    limits.missing_temp    <= cfg_data;
        bfq_pkg::CFG_SELF_TEST:       limits.self_test       <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

endmodule

/* design/bfq_counter_banks.sv */
// ----------------------------------------------------------------------------
// bfq_counter_banks
// Eight banks of saturating fault counters with the sticky fault code and
// the shutdown relay latch. One request is read, updated and written back
// in the cycle it fires; the response is combinational.
// ----------------------------------------------------------------------------
module bfq_counter_banks #(
  parameter int CELLS               = bfq_pkg::DEF_CELLS,
  parameter int CHIPS               = bfq_pkg::DEF_CHIPS,
  parameter int TEMP_SENSORS        = bfq_pkg::DEF_TEMP_SENSORS,
  parameter int CV_GROUPS_PER_CHIP  = bfq_pkg::DEF_CV_GROUPS_PER_CHIP,
  parameter int AUX_GROUPS_PER_CHIP = bfq_pkg::DEF_AUX_GROUPS_PER_CHIP
) (
  input  logic             clk,
  input  logic             rst,
  input  bfq_pkg::req_t    req,
  input  bfq_pkg::limits_t limits,
  output bfq_pkg::rsp_t    rsp
);

  localparam int CV_SECTIONS  = CHIPS * CV_GROUPS_PER_CHIP;
  localparam int AUX_SECTIONS = CHIPS * AUX_GROUPS_PER_CHIP;
  localparam int BANK_SIZE [bfq_pkg::NUM_BANKS] = '{
    CELLS, CV_SECTIONS, CELLS, TEMP_SENSORS,
    AUX_SECTIONS, CV_SECTIONS, AUX_SECTIONS, CHIPS
  };

  logic [bfq_pkg::CNT_W-1:0]  rd_val [bfq_pkg::NUM_BANKS];
  logic [bfq_pkg::NUM_BANKS-1:0] in_range;

  logic [bfq_pkg::CNT_W-1:0]  sel_val;
  logic [bfq_pkg::CNT_W-1:0]  inc_val;
  logic [bfq_pkg::CNT_W-1:0]  wr_val;
  logic [bfq_pkg::CNT_W-1:0]  limit_sel;
  logic [bfq_pkg::CODE_W-1:0] bit_sel;
  logic                       err;
  logic                       trip;
  logic                       clr_all;
  logic                       wr_en;

  logic [bfq_pkg::CODE_W-1:0] fault_bits;
  logic [bfq_pkg::CODE_W-1:0] fault_bits_next;
  logic                       relay_latch;
  logic                       relay_latch_next;

  assign clr_all = req.fire && (req.op == bfq_pkg::OP_REINIT);
  assign wr_en   = req.fire && !err &&
                   ((req.op == bfq_pkg::OP_INC) || (req.op == bfq_pkg::OP_CLEAR));

  for (genvar b = 0; b < bfq_pkg::NUM_BANKS; b++) begin : g_bank
    // Channels above the field's span can never be addressed.
    localparam int DEPTH = (BANK_SIZE[b] < bfq_pkg::CH_SPAN) ?
                           BANK_SIZE[b] : bfq_pkg::CH_SPAN;

    logic [bfq_pkg::CNT_W-1:0] cnt [DEPTH];

    if (BANK_SIZE[b] >= bfq_pkg::CH_SPAN) begin : g_full
      assign in_range[b] = 1'b1;
    end else begin : g_part
      assign in_range[b] = (req.ch < bfq_pkg::CH_W'(BANK_SIZE[b]));
    end

    for (genvar e = 0; e < DEPTH; e++) begin : g_entry
      always_ff @(posedge clk) begin
        if (rst || clr_all) begin
          cnt[e] <= '0;
        end else if (wr_en && (req.cat == bfq_pkg::CAT_W'(b)) &&
                     (req.ch == bfq_pkg::CH_W'(e))) begin
          cnt[e] <= wr_val;
        end
      end
    end

    if (DEPTH == 1) begin : g_single
      assign rd_val[b] = cnt[0];
    end else begin : g_multi
      localparam int IW = $clog2(DEPTH);
      assign rd_val[b] = cnt[req.ch[IW-1:0]];
    end
  end

  always_comb begin
    unique case (req.cat)
      bfq_pkg::CAT_VRANGE: begin
        limit_sel = limits.voltage_range;   bit_sel = bfq_pkg::BIT_VOLTAGE;
      end
      bfq_pkg::CAT_VMISSING: begin
        limit_sel = limits.missing_voltage; bit_sel = bfq_pkg::BIT_VOLTAGE;
      end
      bfq_pkg::CAT_SENSE: begin
        limit_sel = limits.sense_line;      bit_sel = bfq_pkg::BIT_SENSE_LINE;
      end
      bfq_pkg::CAT_TRANGE: begin
        limit_sel = limits.temp_range;      bit_sel = bfq_pkg::BIT_TEMPERATURE;
      end
      bfq_pkg::CAT_TMISSING: begin
        limit_sel = limits.missing_temp;    bit_sel = bfq_pkg::BIT_TEMPERATURE;
      end
      bfq_pkg::CAT_CVTEST,
      bfq_pkg::CAT_AUXTEST,
      bfq_pkg::CAT_MUXTEST: begin
        limit_sel = limits.self_test;       bit_sel = bfq_pkg::BIT_SELF_TEST;
      end
    endcase
  end

  always_comb begin
    sel_val = rd_val[req.cat];
    err     = (req.op != bfq_pkg::OP_REINIT) && !in_range[req.cat];
    // saturate at full scale
    inc_val = (sel_val == bfq_pkg::CNT_MAX) ? sel_val : sel_val + 1'b1;
    wr_val  = (req.op == bfq_pkg::OP_INC) ? inc_val : '0;
    trip    = req.fire && (req.op == bfq_pkg::OP_INC) && !err && (inc_val > limit_sel);

    fault_bits_next  = fault_bits | (trip ? bit_sel : '0);
    relay_latch_next = relay_latch;
    if (clr_all) begin
      relay_latch_next = 1'b1;
    end else if (trip) begin
      relay_latch_next = 1'b0;
    end

    unique case (req.op)
      bfq_pkg::OP_INC:    rsp.count = err ? '0 : inc_val;
      bfq_pkg::OP_READ:   rsp.count = err ? '0 : sel_val;
      bfq_pkg::OP_CLEAR,
      bfq_pkg::OP_REINIT: rsp.count = '0;
    endcase
    rsp.fault_code   = fault_bits_next;
    rsp.relay_closed = relay_latch_next;
    rsp.index_error  = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_bits  <= '0;
      relay_latch <= 1'b1;
    end else if (req.fire) begin
      fault_bits  <= fault_bits_next;
      relay_latch <= relay_latch_next;
    end
  end

  a_reinit_closes_relay: assert property (@(posedge clk) disable iff (rst)
    (req.fire && (req.op == bfq_pkg::OP_REINIT)) |=> relay_latch)
    else $error("relay not closed after reinitialize");

  a_trip_opens_relay: assert property (@(posedge clk) disable iff (rst)
    (req.fire && (req.op == bfq_pkg::OP_INC) && !rsp.index_error &&
     (rsp.count > limit_sel)) |=>
      (!relay_latch && ((fault_bits & $past(bit_sel)) != '0)))
    else $error("tripping increment did not open relay and set fault bit");

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    !rst |=> ((fault_bits & $past(fault_bits)) == $past(fault_bits)))
    else $error("fault code lost a sticky bit");

  a_error_no_count: assert property (@(posedge clk) disable iff (rst)
    (req.fire && rsp.index_error) |-> (rsp.count == '0 && !wr_en))
    else $error("index error with nonzero count or counter write");

endmodule
